[hdl/tgc_pkg.sv]
package tgc_pkg;

   localparam int SizeWidth  = 13;
   localparam int DistWidth  = 12;
   localparam int CoordWidth = 16;
   localparam int PanelWidth = 14;
   localparam int CsrIdxWidth = 4;

   localparam logic [2:0] FUNC_X_POS  = 3'd0;
   localparam logic [2:0] FUNC_Y_POS  = 3'd1;
   localparam logic [2:0] FUNC_TRK_ID = 3'd2;
   localparam logic [2:0] FUNC_BUTTON = 3'd3;
   localparam logic [2:0] FUNC_SYNC   = 3'd4;

   localparam logic [CsrIdxWidth-1:0] CSR_PANEL_WIDTH  = 4'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_PANEL_HEIGHT = 4'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_TAP_MAX      = 4'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_SWIPE_MIN    = 4'd3;

   localparam logic [SizeWidth-1:0] RESET_PANEL_WIDTH  = 13'd172;
   localparam logic [SizeWidth-1:0] RESET_PANEL_HEIGHT = 13'd320;
   localparam logic [DistWidth-1:0] RESET_TAP_MAX      = 12'd18;
   localparam logic [DistWidth-1:0] RESET_SWIPE_MIN    = 12'd40;

   localparam logic signed [CoordWidth-1:0] COORD_UNSET = -16'sd1;

   typedef enum logic [2:0] {
      GEST_TAP   = 3'd0,
      GEST_UP    = 3'd1,
      GEST_DOWN  = 3'd2,
      GEST_LEFT  = 3'd3,
      GEST_RIGHT = 3'd4
   } gesture_type;

   typedef struct packed {
      logic [2:0]                    func;
      logic signed [CoordWidth-1:0]  event_value;
   } req_word_type;

   typedef struct packed {
      gesture_type           gesture;
      logic [DistWidth-1:0]  end_x;
      logic [DistWidth-1:0]  end_y;
   } rsp_word_type;

   typedef struct packed {
      logic [SizeWidth-1:0] panel_width;
      logic [SizeWidth-1:0] panel_height;
      logic [DistWidth-1:0] tap_max;
      logic [DistWidth-1:0] swipe_min;
   } cfg_type;

   // raw points of a finished touch
   typedef struct packed {
      logic signed [CoordWidth-1:0] start_x;
      logic signed [CoordWidth-1:0] start_y;
      logic signed [CoordWidth-1:0] cur_x;
      logic signed [CoordWidth-1:0] cur_y;
   } touch_type;

   // mirrored and clamped points, -1 marks an empty panel
   typedef struct packed {
      logic signed [PanelWidth-1:0] x0;
      logic signed [PanelWidth-1:0] y0;
      logic signed [PanelWidth-1:0] x1;
      logic signed [PanelWidth-1:0] y1;
   } panel_pts_type;

endpackage

[hdl/tgc_track.sv]
module tgc_track (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tgc_pkg::req_word_type req_word,
   input  logic                 next_ready,
   output logic                 job_valid,
   output tgc_pkg::touch_type    job
);
   import tgc_pkg::*;

   logic                         tracking_ff, tracking_in;
   logic signed [CoordWidth-1:0] start_x_ff, start_x_in;
   logic signed [CoordWidth-1:0] start_y_ff, start_y_in;
   logic signed [CoordWidth-1:0] cur_x_ff, cur_x_in;
   logic signed [CoordWidth-1:0] cur_y_ff, cur_y_in;
   logic signed [CoordWidth-1:0] pend_x_ff, pend_x_in;
   logic signed [CoordWidth-1:0] pend_y_ff, pend_y_in;
   logic                         job_valid_ff, job_valid_in;
   touch_type                    job_ff, job_in;
   logic                         accept;
   logic                         finish;
   logic signed [CoordWidth-1:0] v;
   logic signed [CoordWidth-1:0] sync_x, sync_y;

   assign req_stall = job_valid_ff && !next_ready;
   assign accept    = req_valid && !req_stall;
   assign v         = req_word.event_value;
   assign sync_x    = pend_x_ff[CoordWidth-1] ? cur_x_ff : pend_x_ff;
   assign sync_y    = pend_y_ff[CoordWidth-1] ? cur_y_ff : pend_y_ff;

   always_comb begin
      tracking_in = tracking_ff;
      start_x_in  = start_x_ff;
      start_y_in  = start_y_ff;
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      pend_x_in   = pend_x_ff;
      pend_y_in   = pend_y_ff;
      finish      = 1'b0;
      if (accept) begin
         case (req_word.func)
            FUNC_X_POS: begin
               pend_x_in = v;
            end
            FUNC_Y_POS: begin
               pend_y_in = v;
            end
            FUNC_TRK_ID: begin
               if (v[CoordWidth-1]) begin
                  finish      = tracking_ff;
                  tracking_in = 1'b0;
                  start_x_in  = COORD_UNSET;
                  start_y_in  = COORD_UNSET;
                  cur_x_in    = COORD_UNSET;
                  cur_y_in    = COORD_UNSET;
               end else if (!tracking_ff) begin
                  tracking_in = 1'b1;
                  if (!cur_x_ff[CoordWidth-1] && !cur_y_ff[CoordWidth-1]) begin
                     start_x_in = cur_x_ff;
                     start_y_in = cur_y_ff;
                  end
               end
            end
            FUNC_BUTTON: begin
               if (v == 16'sd0 && tracking_ff) begin
                  finish      = 1'b1;
                  tracking_in = 1'b0;
               end else if (v == 16'sd1) begin
                  tracking_in = 1'b1;
                  if (!cur_x_ff[CoordWidth-1] && !cur_y_ff[CoordWidth-1]) begin
                     start_x_in = cur_x_ff;
                     start_y_in = cur_y_ff;
                  end
               end
            end
            FUNC_SYNC: begin
               cur_x_in  = sync_x;
               cur_y_in  = sync_y;
               pend_x_in = COORD_UNSET;
               pend_y_in = COORD_UNSET;
               if (tracking_ff && start_x_ff[CoordWidth-1] &&
                   !sync_x[CoordWidth-1] && !sync_y[CoordWidth-1]) begin
                  start_x_in = sync_x;
                  start_y_in = sync_y;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      job_in.start_x = start_x_ff;
      job_in.start_y = start_y_ff;
      job_in.cur_x   = cur_x_ff;
      job_in.cur_y   = cur_y_ff;
      job_valid_in   = (job_valid_ff && !next_ready) || (accept && finish);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracking_ff  <= 1'b0;
         start_x_ff   <= COORD_UNSET;
         start_y_ff   <= COORD_UNSET;
         cur_x_ff     <= COORD_UNSET;
         cur_y_ff     <= COORD_UNSET;
         pend_x_ff    <= COORD_UNSET;
         pend_y_ff    <= COORD_UNSET;
         job_valid_ff <= 1'b0;
      end else begin
         tracking_ff  <= tracking_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         pend_x_ff    <= pend_x_in;
         pend_y_ff    <= pend_y_in;
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && finish) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

endmodule

[hdl/tgc_mirror.sv]
module tgc_mirror (
   input  logic                  clock,
   input  logic                  reset,
   input  tgc_pkg::cfg_type       cfg,
   input  logic                  job_valid,
   input  tgc_pkg::touch_type     job,
   output logic                  job_ready,
   input  logic                  next_ready,
   output logic                  pts_valid,
   output tgc_pkg::panel_pts_type pts
);
   import tgc_pkg::*;

   localparam int DiffWidth = CoordWidth + 2;

   logic          pts_valid_ff, pts_valid_in;
   panel_pts_type pts_ff, pts_in;

   function automatic logic signed [PanelWidth-1:0] mirror_clamp(
      input logic [SizeWidth-1:0]        size,
      input logic signed [CoordWidth-1:0] t
   );
      logic signed [DiffWidth-1:0] p;
      logic signed [DiffWidth-1:0] size_s;
      logic signed [PanelWidth-1:0] result;
      size_s = $signed({{(DiffWidth-SizeWidth){1'b0}}, size});
      p = size_s - {{(DiffWidth-1){1'b0}}, 1'b1} - DiffWidth'(t);
      priority if (size == '0) begin
         result = -14'sd1;
      end else if (p[DiffWidth-1]) begin
         result = '0;
      end else if (p >= size_s) begin
         result = PanelWidth'(size_s - {{(DiffWidth-1){1'b0}}, 1'b1});
      end else begin
         result = PanelWidth'(p);
      end
      return result;
   endfunction

   assign job_ready = !pts_valid_ff || next_ready;

   always_comb begin
      pts_in.x0 = mirror_clamp(cfg.panel_width, job.start_x);
      pts_in.y0 = mirror_clamp(cfg.panel_height, job.start_y);
      pts_in.x1 = mirror_clamp(cfg.panel_width, job.cur_x);
      pts_in.y1 = mirror_clamp(cfg.panel_height, job.cur_y);
      pts_valid_in = job_ready ? job_valid : pts_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pts_valid_ff <= 1'b0;
      end else begin
         pts_valid_ff <= pts_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_ready && job_valid) begin
         pts_ff <= pts_in;
      end
   end

   assign pts_valid = pts_valid_ff;
   assign pts       = pts_ff;

endmodule

[hdl/tgc_judge.sv]
module tgc_judge (
   input  logic                   clock,
   input  logic                   reset,
   input  tgc_pkg::cfg_type        cfg,
   input  logic                   pts_valid,
   input  tgc_pkg::panel_pts_type  pts,
   output logic                   pts_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tgc_pkg::rsp_word_type   rsp_word
);
   import tgc_pkg::*;

   localparam int DeltaWidth = PanelWidth + 1;
   localparam int AbsWidth   = PanelWidth - 1;
   localparam int ProdWidth  = AbsWidth + 3;

   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_word_type                 rsp_word_ff, rsp_word_in;
   logic signed [DeltaWidth-1:0] dx, dy;
   logic [AbsWidth-1:0]          ax, ay;
   logic [ProdWidth-1:0]         ax5, ay5, ax6, ay6;
   logic [AbsWidth-1:0]          tap_max, swipe_min;
   logic                         any_neg;
   logic                         found;
   gesture_type                  gest;
   logic                         take;

   assign pts_ready = !rsp_valid_ff || !rsp_stall;
   assign take      = pts_valid && pts_ready;

   always_comb begin
      any_neg = pts.x0[PanelWidth-1] || pts.y0[PanelWidth-1] ||
                pts.x1[PanelWidth-1] || pts.y1[PanelWidth-1];
      dx = DeltaWidth'(pts.x1) - DeltaWidth'(pts.x0);
      dy = DeltaWidth'(pts.y1) - DeltaWidth'(pts.y0);
      ax = dx[DeltaWidth-1] ? AbsWidth'(-dx) : AbsWidth'(dx);
      ay = dy[DeltaWidth-1] ? AbsWidth'(-dy) : AbsWidth'(dy);
      ax5 = (ProdWidth'(ax) << 2) + ProdWidth'(ax);
      ay5 = (ProdWidth'(ay) << 2) + ProdWidth'(ay);
      ax6 = (ProdWidth'(ax) << 2) + (ProdWidth'(ax) << 1);
      ay6 = (ProdWidth'(ay) << 2) + (ProdWidth'(ay) << 1);
      tap_max   = AbsWidth'(cfg.tap_max);
      swipe_min = AbsWidth'(cfg.swipe_min);
      found = 1'b1;
      gest  = GEST_TAP;
      // ratio test a > floor(6*b/5) is the same as 5*a > 6*b
      priority if (any_neg) begin
         found = 1'b0;
      end else if (ax <= tap_max && ay <= tap_max) begin
         gest = GEST_TAP;
      end else if (ay >= swipe_min && ay5 > ax6) begin
         gest = dy[DeltaWidth-1] ? GEST_UP : GEST_DOWN;
      end else if (ax >= swipe_min && ax5 > ay6) begin
         gest = (!dx[DeltaWidth-1] && dx != '0) ? GEST_RIGHT : GEST_LEFT;
      end else begin
         found = 1'b0;
      end
      rsp_word_in.gesture = gest;
      rsp_word_in.end_x   = pts.x1[DistWidth-1:0];
      rsp_word_in.end_y   = pts.y1[DistWidth-1:0];
      rsp_valid_in = pts_ready ? (take && found) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && found) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[hdl/touch_gesture_classifier_core.sv]
// touch gesture classifier
// req channel: one touch event word per accepted cycle (func, event_value);
// x/y positions stay pending until a sync word commits them.
// rsp channel: one word per recognized gesture (gesture, end_x, end_y),
// raised on a tracking id below zero or a button release of a tracked touch.
// csr port: write-only, csr_wr_en with csr_index and csr_wdata, taken each
// enabled cycle; writes to unused indexes are dropped.
// a finishing event reaches rsp through three registers in order: touch state,
// then mirrored/clamped points, then the classified word.
// throughput: one event per cycle while req_stall is low.
// the three stages each hold a word, so events keep flowing while a result
// waits; when rsp_stall holds the output word and both inner stages are full,
// req_stall rises until the output word is taken.
// reset: tracking cleared, all points and pending positions unset, csr back
// to panel 172 x 320, tap distance 18, swipe distance 40, no rsp word.
module touch_gesture_classifier_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  tgc_pkg::req_word_type                  req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output tgc_pkg::rsp_word_type                  rsp_word,
   input  logic                                  csr_wr_en,
   input  logic [tgc_pkg::CsrIdxWidth-1:0]        csr_index,
   input  logic [tgc_pkg::SizeWidth-1:0]          csr_wdata
);
   import tgc_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   logic          job_valid;
   touch_type     job;
   logic          job_ready;
   logic          pts_valid;
   panel_pts_type pts;
   logic          pts_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PANEL_WIDTH:  cfg_in.panel_width  = csr_wdata;
            CSR_PANEL_HEIGHT: cfg_in.panel_height = csr_wdata;
            CSR_TAP_MAX:      cfg_in.tap_max      = csr_wdata[DistWidth-1:0];
            CSR_SWIPE_MIN:    cfg_in.swipe_min    = csr_wdata[DistWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.panel_width  <= RESET_PANEL_WIDTH;
         cfg_ff.panel_height <= RESET_PANEL_HEIGHT;
         cfg_ff.tap_max      <= RESET_TAP_MAX;
         cfg_ff.swipe_min    <= RESET_SWIPE_MIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tgc_track u_track (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .next_ready (job_ready),
      .job_valid  (job_valid),
      .job        (job)
   );

   tgc_mirror u_mirror (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .job_valid  (job_valid),
      .job        (job),
      .job_ready  (job_ready),
      .next_ready (pts_ready),
      .pts_valid  (pts_valid),
      .pts        (pts)
   );

   tgc_judge u_judge (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pts_valid (pts_valid),
      .pts       (pts),
      .pts_ready (pts_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

[hdl/tgc_checker.sv]
module tgc_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_stall,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  tgc_pkg::rsp_word_type           rsp_word
);
   import tgc_pkg::*;

   logic [2:0] gest_code;
   assign gest_code = rsp_word.gesture;

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp word present after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled rsp word changed or dropped");

   // input only backs up when the output is held
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled while rsp side is free");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> gest_code <= 3'd4)
      else $error("gesture code out of range");

endmodule

bind touch_gesture_classifier_core tgc_checker u_tgc_checker (.*);
